### hw/rtl/rdr_pkg.sv
// ----------------------------------------------------------------------------
// rdr_pkg
// Shared types, constants and the table square root for the radial remap.
// ----------------------------------------------------------------------------
package rdr_pkg;

	localparam int TABLE_DEPTH_DEF = 2048;
	localparam int MAX_DIM_DEF     = 2048;
	localparam int DIM_W           = 12;
	localparam int COORD_W         = 11;
	localparam int SCALE_W         = 24;
	localparam int MID_DEPTH       = 8;
	localparam int OUT_DEPTH       = 8;

	localparam logic [1:0] REG_WIDTH    = 2'd0;
	localparam logic [1:0] REG_HEIGHT   = 2'd1;
	localparam logic [1:0] REG_SUBPIXEL = 2'd2;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_MAP   = 1'b1;

	typedef struct packed {
		logic                       operation;
		logic [10:0]                entry_index;
		logic signed [SCALE_W-1:0]  entry_scale;
		logic [COORD_W-1:0]         pixel_x;
		logic [COORD_W-1:0]         pixel_y;
	} in_word_t;

	typedef struct packed {
		logic [COORD_W-1:0] source_x;
		logic [COORD_W-1:0] source_y;
		logic [21:0]        source_address;
		logic [7:0]         fraction_x;
		logic [7:0]         fraction_y;
	} out_word_t;

	typedef struct packed {
		logic signed [SCALE_W-1:0] q;
		logic signed [DIM_W-1:0]   dx;
		logic signed [DIM_W-1:0]   dy;
	} mid_word_t;

	// saturated frame settings seen by both halves
	typedef struct packed {
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
		logic             sub;
	} frame_cfg_t;

	localparam logic [7:0] ROOT_ROM [0:255] = '{
		8'd0, 8'd16, 8'd22, 8'd27, 8'd32, 8'd35, 8'd39, 8'd42, 8'd45, 8'd48, 8'd50, 8'd53,
		8'd55, 8'd57, 8'd59, 8'd61, 8'd64, 8'd65, 8'd67, 8'd69, 8'd71, 8'd73, 8'd75, 8'd76,
		8'd78, 8'd80, 8'd81, 8'd83, 8'd84, 8'd86, 8'd87, 8'd89, 8'd90, 8'd91, 8'd93, 8'd94,
		8'd96, 8'd97, 8'd98, 8'd99, 8'd101, 8'd102, 8'd103, 8'd104, 8'd106, 8'd107, 8'd108,
		8'd109, 8'd110, 8'd112, 8'd113, 8'd114, 8'd115, 8'd116, 8'd117, 8'd118, 8'd119,
		8'd120, 8'd121, 8'd122, 8'd123, 8'd124, 8'd125, 8'd126, 8'd128, 8'd128, 8'd129,
		8'd130, 8'd131, 8'd132, 8'd133, 8'd134, 8'd135, 8'd136, 8'd137, 8'd138, 8'd139,
		8'd140, 8'd141, 8'd142, 8'd143, 8'd144, 8'd144, 8'd145, 8'd146, 8'd147, 8'd148,
		8'd149, 8'd150, 8'd150, 8'd151, 8'd152, 8'd153, 8'd154, 8'd155, 8'd155, 8'd156,
		8'd157, 8'd158, 8'd159, 8'd160, 8'd160, 8'd161, 8'd162, 8'd163, 8'd163, 8'd164,
		8'd165, 8'd166, 8'd167, 8'd167, 8'd168, 8'd169, 8'd170, 8'd170, 8'd171, 8'd172,
		8'd173, 8'd173, 8'd174, 8'd175, 8'd176, 8'd176, 8'd177, 8'd178, 8'd178, 8'd179,
		8'd180, 8'd181, 8'd181, 8'd182, 8'd183, 8'd183, 8'd184, 8'd185, 8'd185, 8'd186,
		8'd187, 8'd187, 8'd188, 8'd189, 8'd189, 8'd190, 8'd191, 8'd192, 8'd192, 8'd193,
		8'd193, 8'd194, 8'd195, 8'd195, 8'd196, 8'd197, 8'd197, 8'd198, 8'd199, 8'd199,
		8'd200, 8'd201, 8'd201, 8'd202, 8'd203, 8'd203, 8'd204, 8'd204, 8'd205, 8'd206,
		8'd206, 8'd207, 8'd208, 8'd208, 8'd209, 8'd209, 8'd210, 8'd211, 8'd211, 8'd212,
		8'd212, 8'd213, 8'd214, 8'd214, 8'd215, 8'd215, 8'd216, 8'd217, 8'd217, 8'd218,
		8'd218, 8'd219, 8'd219, 8'd220, 8'd221, 8'd221, 8'd222, 8'd222, 8'd223, 8'd224,
		8'd224, 8'd225, 8'd225, 8'd226, 8'd226, 8'd227, 8'd227, 8'd228, 8'd229, 8'd229,
		8'd230, 8'd230, 8'd231, 8'd231, 8'd232, 8'd232, 8'd233, 8'd234, 8'd234, 8'd235,
		8'd235, 8'd236, 8'd236, 8'd237, 8'd237, 8'd238, 8'd238, 8'd239, 8'd240, 8'd240,
		8'd241, 8'd241, 8'd242, 8'd242, 8'd243, 8'd243, 8'd244, 8'd244, 8'd245, 8'd245,
		8'd246, 8'd246, 8'd247, 8'd247, 8'd248, 8'd248, 8'd249, 8'd249, 8'd250, 8'd250,
		8'd251, 8'd251, 8'd252, 8'd252, 8'd253, 8'd253, 8'd254, 8'd254, 8'd255
	};

	function automatic logic [15:0] rom_at(input logic [31:0] i);
		return {8'h00, ROOT_ROM[i[7:0]]};
	endfunction

	// range select on n, rom lookup, power-of-two rescale
	function automatic logic [15:0] ring_root(input logic [31:0] n);
		logic [15:0] r;
		if (n >= 32'h0001_0000) begin
			if (n >= 32'h0100_0000) begin
				if (n >= 32'h1000_0000) begin
					if (n >= 32'h4000_0000) r = rom_at(n >> 24) << 8;
					else                    r = rom_at(n >> 22) << 7;
				end else if (n >= 32'h0400_0000) r = rom_at(n >> 20) << 6;
				else                             r = rom_at(n >> 18) << 5;
			end else if (n >= 32'h0010_0000) begin
				if (n >= 32'h0040_0000) r = rom_at(n >> 16) << 4;
				else                    r = rom_at(n >> 14) << 3;
			end else if (n >= 32'h0004_0000) r = rom_at(n >> 12) << 2;
			else                             r = rom_at(n >> 10) << 1;
		end else if (n >= 32'h0000_0100) begin
			if (n >= 32'h0000_1000) begin
				if (n >= 32'h0000_4000) r = rom_at(n >> 8);
				else                    r = rom_at(n >> 6) >> 1;
			end else if (n >= 32'h0000_0400) r = rom_at(n >> 4) >> 2;
			else                             r = rom_at(n >> 2) >> 3;
		end else if (n >= 32'h0000_0010) begin
			if (n >= 32'h0000_0040) r = rom_at(n) >> 4;
			else                    r = rom_at(n << 2) << 5;
		end else if (n >= 32'h0000_0004) r = rom_at(n >> 4) << 6;
		else                             r = rom_at(n >> 6) << 7;
		return r;
	endfunction

endpackage

### hw/rtl/rdr_fifo.sv
// ----------------------------------------------------------------------------
// rdr_fifo
// Small synchronous queue, power-of-two depth, first-word fall-through.
// ----------------------------------------------------------------------------
module rdr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       rd_en,
	output logic [WIDTH-1:0]           rdata,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wp_q, rp_q;
	logic [CW-1:0]    cnt_q;
	logic             do_rd;

	assign empty = (cnt_q == '0);
	assign do_rd = rd_en && !empty;
	assign rdata = mem_q[rp_q];
	assign count = cnt_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= wp_q + PW'(1);
			if (do_rd) rp_q <= rp_q + PW'(1);
			cnt_q <= cnt_q + CW'(wr_en) - CW'(do_rd);
		end
	end
endmodule

### hw/rtl/rdr_front.sv
// ----------------------------------------------------------------------------
// rdr_front
// Accepts words, forms ring radius, owns the scale table and looks up q.
// ----------------------------------------------------------------------------
module rdr_front #(
	parameter int TABLE_DEPTH = rdr_pkg::TABLE_DEPTH_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    push,
	output logic                                    full,
	input  rdr_pkg::in_word_t                       in_word,
	input  rdr_pkg::frame_cfg_t                     cfg,
	input  logic [$clog2(rdr_pkg::MID_DEPTH+1)-1:0] mid_count,
	output logic                                    mid_push,
	output rdr_pkg::mid_word_t                      mid_word
);
	import rdr_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int MW = $clog2(MID_DEPTH + 1);

	logic signed [SCALE_W-1:0] mem_q [TABLE_DEPTH];

	logic                      v_s1, v_s2, v_s3, v_s4;
	logic                      op_s1, op_s2, op_s3;
	logic [10:0]               idx_s1, idx_s2, idx_s3;
	logic signed [SCALE_W-1:0] scl_s1, scl_s2, scl_s3, q_s4;
	logic signed [DIM_W-1:0]   dx_s1, dy_s1, dx_s2, dy_s2, dx_s3, dy_s3, dx_s4, dy_s4;
	logic [23:0]               n_s2;
	logic [AW-1:0]             ra_s3;

	logic                      accept;
	logic [DIM_W-1:0]          w2, h2;
	logic signed [DIM_W-1:0]   dx_c, dy_c;
	logic signed [25:0]        n_c;
	logic [15:0]               root_c;
	logic [MW:0]               pend;

	assign w2 = {1'b0, cfg.w[DIM_W-1:1]};
	assign h2 = {1'b0, cfg.h[DIM_W-1:1]};
	assign dx_c = $signed({1'b0, in_word.pixel_x}) - $signed(w2);
	assign dy_c = $signed({1'b0, in_word.pixel_y}) - $signed(h2);
	assign n_c = 26'(dx_s1 * dx_s1) - 26'(dx_s1) + 26'(dy_s1 * dy_s1) + 26'sd256;
	assign root_c = ring_root({8'h00, n_s2});

	// map words in flight ahead of the queue plus those already queued
	assign pend = (MW+1)'(v_s1 && op_s1 == OP_MAP) + (MW+1)'(v_s2 && op_s2 == OP_MAP)
		+ (MW+1)'(v_s3 && op_s3 == OP_MAP) + (MW+1)'(v_s4) + (MW+1)'(mid_count);
	assign full   = (pend >= (MW+1)'(MID_DEPTH));
	assign accept = push && !full;

	assign mid_push    = v_s4;
	assign mid_word.q  = q_s4;
	assign mid_word.dx = dx_s4;
	assign mid_word.dy = dy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3 && op_s3 == OP_MAP;
		end
	end

	always_ff @(posedge clk) begin
		op_s1  <= in_word.operation;
		idx_s1 <= in_word.entry_index;
		scl_s1 <= in_word.entry_scale;
		dx_s1  <= dx_c;
		dy_s1  <= dy_c;
		op_s2  <= op_s1;
		idx_s2 <= idx_s1;
		scl_s2 <= scl_s1;
		dx_s2  <= dx_s1;
		dy_s2  <= dy_s1;
		n_s2   <= n_c[23:0];
		op_s3  <= op_s2;
		idx_s3 <= idx_s2;
		scl_s3 <= scl_s2;
		dx_s3  <= dx_s2;
		dy_s3  <= dy_s2;
		if (32'(root_c) >= TABLE_DEPTH) ra_s3 <= AW'(TABLE_DEPTH - 1);
		else                             ra_s3 <= AW'(root_c);
		dx_s4  <= dx_s3;
		dy_s4  <= dy_s3;
	end

	// writes and reads share one stage so table order follows word order
	always_ff @(posedge clk) begin
		if (v_s3 && op_s3 == OP_WRITE && 32'(idx_s3) < TABLE_DEPTH)
			mem_q[AW'(idx_s3)] <= scl_s3;
		q_s4 <= mem_q[ra_s3];
	end
endmodule

### hw/rtl/rdr_back.sv
// ----------------------------------------------------------------------------
// rdr_back
// Scales the offset, clamps to the frame and forms the linear address.
// ----------------------------------------------------------------------------
module rdr_back (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  rdr_pkg::frame_cfg_t                     cfg,
	input  logic                                    mid_empty,
	input  rdr_pkg::mid_word_t                      mid_word,
	output logic                                    mid_pop,
	input  logic [$clog2(rdr_pkg::OUT_DEPTH+1)-1:0] out_count,
	output logic                                    out_push,
	output rdr_pkg::out_word_t                      out_word
);
	import rdr_pkg::*;

	localparam int OW = $clog2(OUT_DEPTH + 1);

	logic               v_s5, v_s6, v_s7;
	logic signed [36:0] px_s5, py_s5;
	logic [DIM_W-1:0]   sx_s6, sy_s6;
	logic [7:0]         fx_s6, fy_s6;
	out_word_t          res_s7;

	logic [OW:0]        pend;
	logic signed [29:0] cx, cy, wl, hl;
	logic [DIM_W-1:0]   sx_c, sy_c;
	logic [23:0]        addr_c;

	assign pend = (OW+1)'(v_s5) + (OW+1)'(v_s6) + (OW+1)'(v_s7) + (OW+1)'(out_count);
	assign mid_pop = !mid_empty && (pend < (OW+1)'(OUT_DEPTH));

	assign wl = 30'($signed({1'b0, cfg.w}));
	assign hl = 30'($signed({1'b0, cfg.h}));
	assign cx = 30'($signed({1'b0, cfg.w[DIM_W-1:1]})) + 30'(px_s5 >>> 8);
	assign cy = 30'($signed({1'b0, cfg.h[DIM_W-1:1]})) + 30'(py_s5 >>> 8);

	always_comb begin
		if (cx < 0)                         sx_c = '0;
		else if (cfg.sub && cx >= wl - 1)   sx_c = cfg.w - DIM_W'(2);
		else if (!cfg.sub && cx >= wl)      sx_c = cfg.w - DIM_W'(1);
		else                                sx_c = cx[DIM_W-1:0];
		if (cy < 0)                         sy_c = '0;
		else if (cfg.sub && cy >= hl - 1)   sy_c = cfg.h - DIM_W'(2);
		else if (!cfg.sub && cy >= hl)      sy_c = cfg.h - DIM_W'(1);
		else                                sy_c = cy[DIM_W-1:0];
	end

	assign addr_c = sy_s6 * cfg.w + 24'(sx_s6);

	assign out_push = v_s7;
	assign out_word = res_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s5 <= mid_pop;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		px_s5 <= 37'(mid_word.q * mid_word.dx) + 37'sd128;
		py_s5 <= 37'(mid_word.q * mid_word.dy) + 37'sd128;
		sx_s6 <= sx_c;
		sy_s6 <= sy_c;
		fx_s6 <= cfg.sub ? px_s5[7:0] : 8'h00;
		fy_s6 <= cfg.sub ? py_s5[7:0] : 8'h00;
		res_s7.source_x       <= sx_s6[COORD_W-1:0];
		res_s7.source_y       <= sy_s6[COORD_W-1:0];
		res_s7.source_address <= addr_c[21:0];
		res_s7.fraction_x     <= fx_s6;
		res_s7.fraction_y     <= fy_s6;
	end
endmodule

### hw/rtl/radial_distance_remap.sv
// ----------------------------------------------------------------------------
// radial_distance_remap
// Radial remap address generator: per-ring scale table, source point,
// linear address and subpixel fractions for each destination pixel.
//
//   channel  handshake          word
//   in       push / full        in_word_t  (table write or pixel)
//   out      pop / empty        out_word_t (one per pixel word)
//   cfg      cfg_valid/ready    cfg_index, cfg_data
//
// One word per cycle sustained while full stays low. A pixel passes through
// four front stages (offset, radius, root, table read), the middle queue,
// three back stages (multiply, clamp, address), then the result queue.
// full rises when MID_DEPTH pixels sit ahead of the back half; the back half
// stalls on a full result queue. Reset empties both queues; the scale table
// holds no reset value. cfg_ready is always high.
// ----------------------------------------------------------------------------
module radial_distance_remap #(
	parameter int TABLE_DEPTH   = rdr_pkg::TABLE_DEPTH_DEF,
	parameter int MAX_DIMENSION = rdr_pkg::MAX_DIM_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  rdr_pkg::in_word_t  in_word,
	output logic               empty,
	input  logic               pop,
	output rdr_pkg::out_word_t out_word,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [11:0]        cfg_data
);
	import rdr_pkg::*;

	localparam int MW = $clog2(MID_DEPTH + 1);
	localparam int OW = $clog2(OUT_DEPTH + 1);

	logic [DIM_W-1:0] width_q, height_q;
	logic             sub_q;
	frame_cfg_t       cfg;

	logic             mid_push, mid_pop, mid_empty;
	mid_word_t        mid_in, mid_out;
	logic [MW-1:0]    mid_count;
	logic             out_push;
	out_word_t        out_in;
	logic [OW-1:0]    out_count;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(640);
			height_q <= DIM_W'(480);
			sub_q    <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WIDTH:    width_q  <= cfg_data;
				REG_HEIGHT:   height_q <= cfg_data;
				REG_SUBPIXEL: sub_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q < DIM_W'(2))                             cfg.w = DIM_W'(2);
		else if ({1'b0, width_q} > (DIM_W+1)'(MAX_DIMENSION)) cfg.w = DIM_W'(MAX_DIMENSION);
		else                                                  cfg.w = width_q;
		if (height_q < DIM_W'(2))                             cfg.h = DIM_W'(2);
		else if ({1'b0, height_q} > (DIM_W+1)'(MAX_DIMENSION)) cfg.h = DIM_W'(MAX_DIMENSION);
		else                                                   cfg.h = height_q;
		cfg.sub = sub_q;
	end

	rdr_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_word   (in_word),
		.cfg       (cfg),
		.mid_count (mid_count),
		.mid_push  (mid_push),
		.mid_word  (mid_in)
	);

	rdr_fifo #(.WIDTH($bits(mid_word_t)), .DEPTH(MID_DEPTH)) u_mid (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (mid_push),
		.wdata  (mid_in),
		.rd_en  (mid_pop),
		.rdata  (mid_out),
		.empty  (mid_empty),
		.count  (mid_count)
	);

	rdr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.mid_empty (mid_empty),
		.mid_word  (mid_out),
		.mid_pop   (mid_pop),
		.out_count (out_count),
		.out_push  (out_push),
		.out_word  (out_in)
	);

	rdr_fifo #(.WIDTH($bits(out_word_t)), .DEPTH(OUT_DEPTH)) u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (out_push),
		.wdata  (out_in),
		.rd_en  (pop),
		.rdata  (out_word),
		.empty  (empty),
		.count  (out_count)
	);
endmodule

### hw/rtl/rdr_checker.sv
// ----------------------------------------------------------------------------
// rdr_checker
// Port-level checks for radial_distance_remap, bound to the top level.
// ----------------------------------------------------------------------------
module rdr_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               push,
	input logic               full,
	input rdr_pkg::in_word_t  in_word,
	input logic               empty,
	input logic               pop,
	input rdr_pkg::out_word_t out_word,
	input logic               cfg_valid,
	input logic               cfg_ready,
	input logic [1:0]         cfg_index,
	input logic [11:0]        cfg_data
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_word))
		else $error("result word changed while stalled");

	a_full_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push && !full))
		else $error("full rose without an accepted word");

	a_idle_full: assert property (@(posedge clk) disable iff (!arst_n)
		!push && !full |=> !full)
		else $error("full rose while input idle");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write refused");
endmodule

bind radial_distance_remap rdr_checker u_rdr_checker (.*);

### sim/rdr_scoreboard.sv
// ----------------------------------------------------------------------------
// rdr_scoreboard
// Watches the word, result and register channels of the radial remap block,
// keeps its own scale table and frame settings, predicts every pixel result
// and compares the whole word with what the block returns.
// ----------------------------------------------------------------------------
module rdr_scoreboard (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  rdr_pkg::in_word_t  in_word,
	input  logic               empty,
	input  logic               pop,
	input  rdr_pkg::out_word_t out_word,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [11:0]        cfg_data,
	output int                 errors,
	output int                 pending
);
	import rdr_pkg::*;

	logic [11:0]               width_reg = 12'd640;
	logic [11:0]               height_reg = 12'd480;
	logic                      sub_reg = 1'b0;
	logic signed [SCALE_W-1:0] scale_mem [0:TABLE_DEPTH_DEF-1];
	out_word_t                 expected_words [$];

	function automatic int unsigned root_of(input logic [31:0] n);
		logic [31:0] r;
		if (n >= 32'h4000_0000)      r = ROOT_ROM[8'(n >> 24)] << 8;
		else if (n >= 32'h1000_0000) r = ROOT_ROM[8'(n >> 22)] << 7;
		else if (n >= 32'h0400_0000) r = ROOT_ROM[8'(n >> 20)] << 6;
		else if (n >= 32'h0100_0000) r = ROOT_ROM[8'(n >> 18)] << 5;
		else if (n >= 32'h0040_0000) r = ROOT_ROM[8'(n >> 16)] << 4;
		else if (n >= 32'h0010_0000) r = ROOT_ROM[8'(n >> 14)] << 3;
		else if (n >= 32'h0004_0000) r = ROOT_ROM[8'(n >> 12)] << 2;
		else if (n >= 32'h0001_0000) r = ROOT_ROM[8'(n >> 10)] << 1;
		else if (n >= 32'h0000_4000) r = ROOT_ROM[8'(n >> 8)];
		else if (n >= 32'h0000_1000) r = ROOT_ROM[8'(n >> 6)] >> 1;
		else if (n >= 32'h0000_0400) r = ROOT_ROM[8'(n >> 4)] >> 2;
		else if (n >= 32'h0000_0100) r = ROOT_ROM[8'(n >> 2)] >> 3;
		else if (n >= 32'h0000_0040) r = ROOT_ROM[8'(n)] >> 4;
		else if (n >= 32'h0000_0010) r = ROOT_ROM[8'(n << 2)] << 5;
		else if (n >= 32'h0000_0004) r = ROOT_ROM[8'(n >> 4)] << 6;
		else                         r = ROOT_ROM[8'(n >> 6)] << 7;
		return r;
	endfunction

	function automatic longint sat_dim(input logic [11:0] d);
		if (d < 2) return 2;
		if (d > MAX_DIM_DEF) return MAX_DIM_DEF;
		return longint'(d);
	endfunction

	function automatic longint clamp_to(input longint c, input longint size, input logic sub);
		if (c < 0) return 0;
		if (sub && c >= size - 1) return size - 2;
		if (!sub && c >= size) return size - 1;
		return c;
	endfunction

	function automatic out_word_t remap_pixel(input in_word_t w_in);
		longint      w, h, dx, dy, q, px, py, sx, sy;
		logic [31:0] n;
		int unsigned root;
		out_word_t   r;
		w = sat_dim(width_reg);
		h = sat_dim(height_reg);
		dx = longint'(w_in.pixel_x) - w / 2;
		dy = longint'(w_in.pixel_y) - h / 2;
		n = 32'(dx * dx - dx + dy * dy + 256);
		root = root_of(n) & 32'hffff;
		if (root >= TABLE_DEPTH_DEF) root = TABLE_DEPTH_DEF - 1;
		q = longint'(scale_mem[root]);
		px = q * dx + 128;
		py = q * dy + 128;
		sx = clamp_to(w / 2 + (px >>> 8), w, sub_reg);
		sy = clamp_to(h / 2 + (py >>> 8), h, sub_reg);
		r.source_x = 11'(sx);
		r.source_y = 11'(sy);
		r.source_address = 22'(sy * w + sx);
		r.fraction_x = sub_reg ? 8'(px) : 8'd0;
		r.fraction_y = sub_reg ? 8'(py) : 8'd0;
		return r;
	endfunction

	initial errors = 0;
	assign pending = expected_words.size();

	always @(posedge clk) begin
		out_word_t exp_word;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WIDTH:    width_reg <= cfg_data;
					REG_HEIGHT:   height_reg <= cfg_data;
					REG_SUBPIXEL: sub_reg <= cfg_data[0];
					default: ;
				endcase
			end
			if (push && !full) begin
				if (in_word.operation == OP_WRITE)
					scale_mem[in_word.entry_index] <= in_word.entry_scale;
				else
					expected_words.push_back(remap_pixel(in_word));
			end
			if (pop && !empty) begin
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected result word x=%0d y=%0d", $time,
						out_word.source_x, out_word.source_y);
					errors <= errors + 1;
				end else begin
					exp_word = expected_words.pop_front();
					if (out_word !== exp_word) begin
						$display("%0t: mismatch exp x=%0d y=%0d a=%0d fx=%0d fy=%0d", $time,
							exp_word.source_x, exp_word.source_y, exp_word.source_address,
							exp_word.fraction_x, exp_word.fraction_y);
						$display("%0t:          got x=%0d y=%0d a=%0d fx=%0d fy=%0d", $time,
							out_word.source_x, out_word.source_y, out_word.source_address,
							out_word.fraction_x, out_word.fraction_y);
						errors <= errors + 1;
					end
				end
			end
		end
	end

endmodule

### sim/tb_radial_distance_remap.sv
// ----------------------------------------------------------------------------
// tb_radial_distance_remap
// Writes every reachable scale table entry, then runs pixel and table words
// through eight frame settings, the first six with random stalls on both sides
// and the last two without; the scoreboard checks every result word.
// ----------------------------------------------------------------------------
module tb_radial_distance_remap;
	import rdr_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      push = 1'b0;
	logic      full;
	in_word_t  in_word = '0;
	logic      empty;
	logic      pop = 1'b0;
	out_word_t out_word;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic [1:0]  cfg_index = REG_WIDTH;
	logic [11:0] cfg_data = '0;
	int        errors, pending;
	int        send_idle_pct = 37, recv_idle_pct = 77;
	int        cycles = 0, pixels_sent = 0, writes_sent = 0;
	int        cur_w = 640, cur_h = 480;

	always #10 clk = ~clk;

	radial_distance_remap DUT (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_word(in_word),
		.empty(empty), .pop(pop), .out_word(out_word), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	rdr_scoreboard checker_i (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_word(in_word),
		.empty(empty), .pop(pop), .out_word(out_word), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(negedge clk) pop <= ($urandom_range(99) >= recv_idle_pct);

	task automatic send_word(input in_word_t w);
		logic ok;
		while ($urandom_range(99) < send_idle_pct) begin
			push = 1'b0;
			in_word = in_word_t'($bits(in_word_t)'({$urandom, $urandom}));
			@(negedge clk);
		end
		push = 1'b1;
		in_word = w;
		forever begin
			ok = !full;
			@(negedge clk);
			if (ok) break;
		end
		if (w.operation == OP_MAP) pixels_sent++;
		else writes_sent++;
	endtask

	task automatic write_table(input int idx, input int scale);
		in_word_t w;
		w = in_word_t'($bits(in_word_t)'({$urandom, $urandom}));
		w.operation = OP_WRITE;
		w.entry_index = 11'(idx);
		w.entry_scale = 24'(scale);
		send_word(w);
	endtask

	task automatic map_pixel(input int x, input int y);
		in_word_t w;
		w = in_word_t'($bits(in_word_t)'({$urandom, $urandom}));
		w.operation = OP_MAP;
		w.pixel_x = 11'(x);
		w.pixel_y = 11'(y);
		send_word(w);
	endtask

	task automatic write_reg(input logic [1:0] idx, input int data);
		push = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (16) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = 12'(data);
		while (!cfg_ready) @(negedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_frame(input int w, input int h, input int sub);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_SUBPIXEL, sub);
		cur_w = (w < 2) ? 2 : (w > MAX_DIM_DEF) ? MAX_DIM_DEF : w;
		cur_h = (h < 2) ? 2 : (h > MAX_DIM_DEF) ? MAX_DIM_DEF : h;
	endtask

	function automatic int rand_scale();
		int r;
		r = $urandom_range(99);
		if (r < 70) return $urandom_range(512) - 128;
		if (r < 85) return $urandom_range(4096) - 2048;
		return int'($urandom);
	endfunction

	initial begin
		int frame_w [8] = '{640, 2, 2048, 0, 4095, 17, 2048, 300};
		int frame_h [8] = '{480, 2, 2048, 1, 3000, 1024, 2048, 3};
		int frame_s [8] = '{0, 1, 0, 1, 1, 0, 1, 0};
		int x, y;
		int root_idx;
		logic needed [TABLE_DEPTH_DEF];
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// above 0x4000 the root only depends on n in 256-word blocks
		for (int i = 0; i < TABLE_DEPTH_DEF; i++) needed[i] = 1'b0;
		for (int n = 0; n < 32'h0100_0000; n += (n < 32'h0000_4000) ? 1 : 256) begin
			root_idx = int'(ring_root(32'(n)));
			if (root_idx >= TABLE_DEPTH_DEF) root_idx = TABLE_DEPTH_DEF - 1;
			needed[root_idx] = 1'b1;
		end

		// every reachable entry written before any pixel can reach it
		for (int i = 0; i < TABLE_DEPTH_DEF; i++) begin
			if (!needed[i]) continue;
			if (i == 0) write_table(i, 8388607);
			else if (i == TABLE_DEPTH_DEF - 1) write_table(i, -8388608);
			else write_table(i, rand_scale());
		end

		for (int p = 0; p < 8; p++) begin
			if (p == 3) begin send_idle_pct = 77; recv_idle_pct = 37; end
			if (p == 6) begin send_idle_pct = 0; recv_idle_pct = 0; end
			set_frame(frame_w[p], frame_h[p], frame_s[p]);
			map_pixel(0, 0);
			map_pixel(2047, 2047);
			map_pixel(cur_w / 2, cur_h / 2);
			map_pixel(2047, 0);
			map_pixel(0, 2047);
			map_pixel(cur_w - 1, cur_h - 1);
			for (int k = 0; k < 135; k++) begin
				if ($urandom_range(99) < 20) begin
					write_table($urandom_range(TABLE_DEPTH_DEF - 1), rand_scale());
				end else begin
					if ($urandom_range(99) < 85) begin
						x = $urandom_range(cur_w - 1);
						y = $urandom_range(cur_h - 1);
					end else begin
						x = $urandom_range(2047);
						y = $urandom_range(2047);
					end
					map_pixel(x, y);
				end
			end
		end

		push = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		$display("Covered %0d pixel words and %0d table writes over 8 frame settings,",
			pixels_sent, writes_sent);
		$display("including tiny, full-size and saturated frames with and without subpixel.");
		if (errors == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end

endmodule
